>>> sv/rsi_pkg.sv
// package for the ray / wall-segment intersection unit
// widths, field layout and shared types; no dependencies
`default_nettype none
package rsi_pkg;
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int IN_W      = 8 * COORD_W;
    localparam int OUT_W     = 72;

    // per-item terms carried from the cross-product stages into the divider
    typedef struct packed {
        logic                       hit;
        logic [CROSS_W-1:0]         tmag;
        logic [CROSS_W-1:0]         dmag;
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [DIFF_W-1:0]   dx;
        logic signed [DIFF_W-1:0]   dy;
    } rsi_term_t;
endpackage
`default_nettype wire

>>> sv/ray_segment_intersect_2d_unit.sv
// top level of the ray / wall-segment intersection unit
// depends on rsi_pkg, rsi_cross, rsi_div and rsi_lerp
`default_nettype none
// Takes one wall segment and one ray per request, all Q16.16 signed, and
// returns hit plus the crossing point (-1.0, -1.0 on a miss). Fully pipelined:
// one request per cycle while not stalled, through the cross-product stages,
// the one-bit-per-stage divider and the interpolation stages. Backpressure
// stalls the whole pipeline in place; the output register holds a result until
// taken while the pipeline keeps moving when that register is empty or being
// drained.
module ray_segment_intersect_2d_unit #(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // wall_ax, wall_ay, wall_bx, wall_by, ray_origin_x, ray_origin_y,
    // ray_dir_x, ray_dir_y
    input  wire logic [rsi_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // hit, point_x, point_y, zero fill
    output logic [rsi_pkg::OUT_W-1:0]      m_axis_tdata
);
    localparam int CW = rsi_pkg::COORD_W;

    logic en;
    logic               cv, dv, lv;
    rsi_pkg::rsi_term_t cterm, dterm;
    logic [FRAC_BITS-1:0] quot;
    logic               hit;
    logic [CW-1:0]      px, py;

    // advance when the tail slot is empty or being taken
    assign en            = !lv || m_axis_tready;
    assign s_axis_tready = en;

    rsi_cross u_cross (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_axis_tvalid && en), .in_data(s_axis_tdata),
        .out_valid(cv), .out_term(cterm)
    );

    rsi_div #(.FRAC(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(cv), .in_term(cterm),
        .out_valid(dv), .out_term(dterm), .out_quot(quot)
    );

    rsi_lerp #(.FRAC(FRAC_BITS)) u_lerp (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(dv), .in_term(dterm), .in_quot(quot),
        .out_valid(lv), .out_hit(hit), .out_x(px), .out_y(py)
    );

    assign m_axis_tvalid = lv;
    assign m_axis_tdata  = {7'b0, py, px, hit};
endmodule
`default_nettype wire

>>> sv/rsi_cross.sv
// cross-product front end: differences, products, den/tn/un, hit decision
// depends on rsi_pkg; four register stages with stall through enable
`default_nettype none
module rsi_cross (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic [rsi_pkg::IN_W-1:0]            in_data,
    output logic                                     out_valid,
    output rsi_pkg::rsi_term_t                       out_term
);
    localparam int CW = rsi_pkg::COORD_W;
    localparam int DW = rsi_pkg::DIFF_W;
    localparam int PW = rsi_pkg::PROD_W;
    localparam int XW = rsi_pkg::CROSS_W;

    logic signed [CW-1:0] ax, ay, bx, by, ox, oy, rdx, rdy;
    assign ax  = in_data[0*CW +: CW];
    assign ay  = in_data[1*CW +: CW];
    assign bx  = in_data[2*CW +: CW];
    assign by  = in_data[3*CW +: CW];
    assign ox  = in_data[4*CW +: CW];
    assign oy  = in_data[5*CW +: CW];
    assign rdx = in_data[6*CW +: CW];
    assign rdy = in_data[7*CW +: CW];

    // stage 1: coordinate differences
    logic                 v1_reg;
    logic signed [DW-1:0] abx_reg, aby_reg, aox_reg, aoy_reg, dx_reg, dy_reg;
    logic signed [DW-1:0] bax_reg, bay_reg;
    logic signed [CW-1:0] ax1_reg, ay1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abx_reg <= DW'(ax) - DW'(bx);
            aby_reg <= DW'(ay) - DW'(by);
            aox_reg <= DW'(ax) - DW'(ox);
            aoy_reg <= DW'(ay) - DW'(oy);
            bax_reg <= DW'(bx) - DW'(ax);
            bay_reg <= DW'(by) - DW'(ay);
            dx_reg  <= DW'(rdx);
            dy_reg  <= DW'(rdy);
            ax1_reg <= ax;
            ay1_reg <= ay;
        end
    end

    // stage 2: six products
    logic                 v2_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [DW-1:0] bax2_reg, bay2_reg;
    logic signed [CW-1:0] ax2_reg, ay2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg   <= PW'(aby_reg) * PW'(dx_reg);
            p1_reg   <= PW'(abx_reg) * PW'(dy_reg);
            p2_reg   <= PW'(aoy_reg) * PW'(dx_reg);
            p3_reg   <= PW'(aox_reg) * PW'(dy_reg);
            p4_reg   <= PW'(aby_reg) * PW'(aox_reg);
            p5_reg   <= PW'(abx_reg) * PW'(aoy_reg);
            bax2_reg <= bax_reg;
            bay2_reg <= bay_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
        end
    end

    // stage 3: cross terms
    logic                 v3_reg;
    logic signed [XW-1:0] den_reg, tn_reg, un_reg;
    logic signed [DW-1:0] bax3_reg, bay3_reg;
    logic signed [CW-1:0] ax3_reg, ay3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= XW'(p0_reg) - XW'(p1_reg);
            tn_reg   <= XW'(p2_reg) - XW'(p3_reg);
            un_reg   <= XW'(p4_reg) - XW'(p5_reg);
            bax3_reg <= bax2_reg;
            bay3_reg <= bay2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
        end
    end

    // stage 4: magnitudes and hit test
    logic          dneg;
    logic [XW-1:0] dmag, tmag;
    logic          hit;
    assign dneg = den_reg[XW-1];
    assign dmag = dneg ? -den_reg : den_reg;
    assign tmag = tn_reg[XW-1] ? -tn_reg : tn_reg;
    assign hit  = (den_reg != '0) && (tn_reg != '0) && (tn_reg[XW-1] == dneg)
               && (tmag < dmag) && (un_reg != '0) && (un_reg[XW-1] == dneg);

    logic               v4_reg;
    rsi_pkg::rsi_term_t term_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg.hit  <= hit;
            term_reg.tmag <= tmag;
            term_reg.dmag <= dmag;
            term_reg.ax   <= ax3_reg;
            term_reg.ay   <= ay3_reg;
            term_reg.dx   <= bax3_reg;
            term_reg.dy   <= bay3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_term  = term_reg;
endmodule
`default_nettype wire

>>> sv/rsi_div.sv
// pipelined restoring divider: one quotient bit per stage
// depends on rsi_pkg; yields tq = floor(tmag * 2^FRAC / dmag) when tmag < dmag
`default_nettype none
module rsi_div #(
    parameter int FRAC = rsi_pkg::FRAC_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire rsi_pkg::rsi_term_t in_term,
    output logic                    out_valid,
    output rsi_pkg::rsi_term_t      out_term,
    output logic [FRAC-1:0]         out_quot
);
    localparam int XW = rsi_pkg::CROSS_W;

    logic               v_reg    [FRAC];
    rsi_pkg::rsi_term_t term_reg [FRAC];
    logic [XW-1:0]      rem_reg  [FRAC];
    logic [FRAC-1:0]    quot_reg [FRAC];

    // one stage per quotient bit
    for (genvar s = 0; s < FRAC; s++)
    begin : g_stage
        logic               v_in;
        rsi_pkg::rsi_term_t t_in;
        logic [XW-1:0]      r_in;
        logic [FRAC-1:0]    q_in;
        logic [XW:0]        shifted;
        logic               ge;

        if (s == 0)
        begin : g_first
            assign v_in = in_valid;
            assign t_in = in_term;
            assign r_in = in_term.tmag;
            assign q_in = '0;
        end
        else
        begin : g_next
            assign v_in = v_reg[s-1];
            assign t_in = term_reg[s-1];
            assign r_in = rem_reg[s-1];
            assign q_in = quot_reg[s-1];
        end

        assign shifted = {r_in, 1'b0};
        assign ge      = shifted >= {1'b0, t_in.dmag};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                term_reg[s] <= t_in;
                rem_reg[s]  <= ge ? XW'(shifted - {1'b0, t_in.dmag}) : XW'(shifted);
                quot_reg[s] <= {q_in[FRAC-2:0], ge};
            end
        end
    end

    assign out_valid = v_reg[FRAC-1];
    assign out_term  = term_reg[FRAC-1];
    assign out_quot  = quot_reg[FRAC-1];
endmodule
`default_nettype wire

>>> sv/rsi_lerp.sv
// point along the wall: A + trunc(tq * (B - A) / 2^FRAC), miss gives -1.0
// depends on rsi_pkg; two register stages
`default_nettype none
module rsi_lerp #(
    parameter int FRAC = rsi_pkg::FRAC_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire rsi_pkg::rsi_term_t            in_term,
    input  wire logic [FRAC-1:0]               in_quot,
    output logic                               out_valid,
    output logic                               out_hit,
    output logic [rsi_pkg::COORD_W-1:0]        out_x,
    output logic [rsi_pkg::COORD_W-1:0]        out_y
);
    localparam int CW = rsi_pkg::COORD_W;
    localparam int DW = rsi_pkg::DIFF_W;
    localparam int MW = DW + FRAC;

    logic [DW-1:0] magx, magy;
    assign magx = in_term.dx[DW-1] ? DW'(-in_term.dx) : DW'(in_term.dx);
    assign magy = in_term.dy[DW-1] ? DW'(-in_term.dy) : DW'(in_term.dy);

    // stage 1: products
    logic          v1_reg, hit1_reg, nx_reg, ny_reg;
    logic [MW-1:0] px_reg, py_reg;
    logic [CW-1:0] ax_reg, ay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit1_reg <= in_term.hit;
            nx_reg   <= in_term.dx[DW-1];
            ny_reg   <= in_term.dy[DW-1];
            px_reg   <= MW'(magx) * MW'(in_quot);
            py_reg   <= MW'(magy) * MW'(in_quot);
            ax_reg   <= in_term.ax;
            ay_reg   <= in_term.ay;
        end
    end

    // stage 2: add and select
    logic [CW-1:0] sx, sy, miss;
    assign sx   = px_reg[FRAC +: CW];
    assign sy   = py_reg[FRAC +: CW];
    assign miss = CW'(0) - (CW'(1) << FRAC);

    logic          v2_reg, hit2_reg;
    logic [CW-1:0] x_reg, y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit2_reg <= hit1_reg;
            x_reg    <= !hit1_reg ? miss : (nx_reg ? ax_reg - sx : ax_reg + sx);
            y_reg    <= !hit1_reg ? miss : (ny_reg ? ay_reg - sy : ay_reg + sy);
        end
    end

    assign out_valid = v2_reg;
    assign out_hit   = hit2_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
endmodule
`default_nettype wire

>>> sv/rsi_check.sv
// port-level checker for the intersection unit, bound to the top level
// depends on rsi_pkg
`default_nettype none
module rsi_check (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     s_axis_tready,
    input wire logic                     m_axis_tvalid,
    input wire logic                     m_axis_tready,
    input wire logic [rsi_pkg::OUT_W-1:0] m_axis_tdata
);
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // input side is open whenever the output is drained
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("request refused while output drains");

    // a miss always reports the fixed point -1.0
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |->
        m_axis_tdata[32:1] == 32'hFFFF0000 && m_axis_tdata[64:33] == 32'hFFFF0000)
        else $error("miss without -1 point");

    // pad bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:65] == 7'b0)
        else $error("pad bits set");
endmodule

bind ray_segment_intersect_2d_unit rsi_check u_rsi_check (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
